@@ sv/two_hop_label_max_product_query_core_assert.svh @@
// ----------------------------------------------------------------------------
// Two-hop label query core: assertion macros
// Shared property forms for the checks in the query core modules.
// ----------------------------------------------------------------------------
`ifndef TWO_HOP_LABEL_MAX_PRODUCT_QUERY_CORE_ASSERT_SVH
`define TWO_HOP_LABEL_MAX_PRODUCT_QUERY_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define THLMPQ_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define THLMPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/thlmpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core: package
// Sizes, label entry and queue command types shared by the query core.
// ----------------------------------------------------------------------------
`default_nettype none

package thlmpq_pkg;

  localparam int MAX_LABELS  = 64;
  localparam int VERTEX_BITS = 20;
  localparam int NODE_BITS   = 20;
  localparam int RANK_BITS   = 20;
  localparam int PROB_BITS   = 17;
  localparam int FRAC_BITS   = 16;

  localparam int CNT_W  = $clog2(MAX_LABELS + 1);
  localparam int ADDR_W = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

  localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(65536);

  localparam logic SEL_FWD = 1'b0;
  localparam logic SEL_BWD = 1'b1;

  typedef struct packed {
    logic [NODE_BITS-1:0] node;
    logic [RANK_BITS-1:0] rank;
    logic [PROB_BITS-1:0] prob;
  } entry_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_sel;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            entry;
    logic              merge;
    logic [CNT_W-1:0]  fwd_count;
    logic [CNT_W-1:0]  bwd_count;
    logic              overflow;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/thlmpq_front.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core: front end
// Accepts label items, tracks list counts and completion, and issues store
// and merge commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module thlmpq_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // tdata: has_entry, landmark_node, landmark_rank, path_prob (lowest bit up)
  input  wire logic [thlmpq_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: list_select
  input  wire logic                                s_tuser,
  input  wire logic                                s_tlast,
  output logic                                     q_push,
  output thlmpq_pkg::cmd_t                         q_cmd,
  input  wire logic                                q_ready
);

  localparam int NODE_LO = 1;
  localparam int RANK_LO = NODE_LO + thlmpq_pkg::NODE_BITS;
  localparam int PROB_LO = RANK_LO + thlmpq_pkg::RANK_BITS;

  logic [thlmpq_pkg::CNT_W-1:0]     fwd_count;
  logic [thlmpq_pkg::CNT_W-1:0]     bwd_count;
  logic [1:0]                       lists_done;
  logic                             overflow_seen;

  logic                             accept;
  logic                             sel;
  logic                             has;
  logic [thlmpq_pkg::PROB_BITS-1:0] prob_in;
  logic [thlmpq_pkg::CNT_W-1:0]     cur_count;
  logic                             closed;
  logic                             room;
  logic                             do_wr;
  logic                             do_ovf;
  logic [1:0]                       done_next;
  logic                             merge;
  logic [thlmpq_pkg::CNT_W-1:0]     fwd_count_next;
  logic [thlmpq_pkg::CNT_W-1:0]     bwd_count_next;
  logic                             overflow_next;

  assign s_tready = q_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    sel       = s_tuser;
    has       = s_tdata[0];
    prob_in   = s_tdata[PROB_LO +: thlmpq_pkg::PROB_BITS];
    cur_count = (sel == thlmpq_pkg::SEL_BWD) ? bwd_count : fwd_count;
    closed    = lists_done[sel];
    room      = cur_count < thlmpq_pkg::CNT_W'(thlmpq_pkg::MAX_LABELS);
    do_wr     = !closed && has && room;
    do_ovf    = !closed && has && !room;
    done_next = lists_done;
    if (!closed && s_tlast) begin
      done_next[sel] = 1'b1;
    end
    merge          = (done_next == 2'b11);
    fwd_count_next = fwd_count + thlmpq_pkg::CNT_W'(do_wr && (sel == thlmpq_pkg::SEL_FWD));
    bwd_count_next = bwd_count + thlmpq_pkg::CNT_W'(do_wr && (sel == thlmpq_pkg::SEL_BWD));
    overflow_next  = overflow_seen || do_ovf;

    q_cmd.wr_en       = do_wr;
    q_cmd.wr_sel      = sel;
    q_cmd.wr_addr     = cur_count[thlmpq_pkg::ADDR_W-1:0];
    q_cmd.entry.node  = s_tdata[NODE_LO +: thlmpq_pkg::NODE_BITS];
    q_cmd.entry.rank  = s_tdata[RANK_LO +: thlmpq_pkg::RANK_BITS];
    q_cmd.entry.prob  = (prob_in > thlmpq_pkg::PROB_ONE) ? thlmpq_pkg::PROB_ONE : prob_in;
    q_cmd.merge       = merge;
    q_cmd.fwd_count   = fwd_count_next;
    q_cmd.bwd_count   = bwd_count_next;
    q_cmd.overflow    = overflow_next;
    q_push            = accept && (do_wr || merge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_count     <= '0;
      bwd_count     <= '0;
      lists_done    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (merge) begin
        fwd_count     <= '0;
        bwd_count     <= '0;
        lists_done    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        fwd_count     <= fwd_count_next;
        bwd_count     <= bwd_count_next;
        lists_done    <= done_next;
        overflow_seen <= overflow_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/thlmpq_queue.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core: command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module thlmpq_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire thlmpq_pkg::cmd_t push_cmd,
  output logic                  push_ready,
  input  wire logic             pop,
  output thlmpq_pkg::cmd_t      pop_cmd,
  output logic                  pop_valid
);

  thlmpq_pkg::cmd_t                  slots [thlmpq_pkg::QUEUE_DEPTH];
  logic [thlmpq_pkg::QPTR_W-1:0]     wr_ptr;
  logic [thlmpq_pkg::QPTR_W-1:0]     rd_ptr;
  logic [thlmpq_pkg::QCNT_W-1:0]     fill;

  assign push_ready = fill != thlmpq_pkg::QCNT_W'(thlmpq_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + thlmpq_pkg::QCNT_W'(push) - thlmpq_pkg::QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ sv/thlmpq_back.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core: back end
// Holds both label stores, runs the rank-ordered merge with one multiplier
// and presents the result through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_hop_label_max_product_query_core_assert.svh"

module thlmpq_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire thlmpq_pkg::cmd_t                    q_cmd,
  input  wire logic                                q_valid,
  output logic                                     q_pop,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tdata: best_prob, overflow (lowest bit up)
  output logic [thlmpq_pkg::OUT_DATA_W-1:0]        m_tdata
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_EVAL,
    B_DRAIN,
    B_OUT
  } state_t;

  localparam int PROD_W = 2 * thlmpq_pkg::PROB_BITS;

  state_t                            state;
  thlmpq_pkg::entry_t                fwd_mem [thlmpq_pkg::MAX_LABELS];
  thlmpq_pkg::entry_t                bwd_mem [thlmpq_pkg::MAX_LABELS];
  thlmpq_pkg::entry_t                f_rd;
  thlmpq_pkg::entry_t                b_rd;
  logic [thlmpq_pkg::CNT_W-1:0]      fcnt;
  logic [thlmpq_pkg::CNT_W-1:0]      bcnt;
  logic [thlmpq_pkg::CNT_W-1:0]      i_idx;
  logic [thlmpq_pkg::CNT_W-1:0]      j_idx;
  logic                              ovf;
  logic [thlmpq_pkg::PROB_BITS-1:0]  prod;
  logic                              prod_vld;
  logic [thlmpq_pkg::PROB_BITS-1:0]  best;
  logic [thlmpq_pkg::PROB_BITS-1:0]  out_best;
  logic                              out_ovf;
  logic                              out_valid;

  logic                              more;
  logic                              node_eq;
  logic [PROD_W-1:0]                 prod_full;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign more     = (i_idx < fcnt) && (j_idx < bcnt);
  assign node_eq  = f_rd.node[thlmpq_pkg::VERTEX_BITS-1:0] ==
                    b_rd.node[thlmpq_pkg::VERTEX_BITS-1:0];
  assign prod_full = PROD_W'(f_rd.prob) * PROD_W'(b_rd.prob);
  assign m_tvalid = out_valid;
  assign m_tdata  = {(thlmpq_pkg::OUT_DATA_W - thlmpq_pkg::PROB_BITS - 1)'(0), out_ovf, out_best};

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr_en && (q_cmd.wr_sel == thlmpq_pkg::SEL_FWD)) begin
      fwd_mem[q_cmd.wr_addr] <= q_cmd.entry;
    end
    if (state == B_READ) begin
      f_rd <= fwd_mem[i_idx[thlmpq_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.wr_en && (q_cmd.wr_sel == thlmpq_pkg::SEL_BWD)) begin
      bwd_mem[q_cmd.wr_addr] <= q_cmd.entry;
    end
    if (state == B_READ) begin
      b_rd <= bwd_mem[j_idx[thlmpq_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
      i_idx     <= '0;
      j_idx     <= '0;
    end else begin
      prod_vld <= (state == B_EVAL) && !(b_rd.rank < f_rd.rank) && node_eq;
      if (out_valid && m_tready && (state != B_OUT)) begin
        out_valid <= 1'b0;
      end
      if (prod_vld && (prod > best)) begin
        best <= prod;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop && q_cmd.merge) begin
            fcnt  <= q_cmd.fwd_count;
            bcnt  <= q_cmd.bwd_count;
            ovf   <= q_cmd.overflow;
            i_idx <= '0;
            j_idx <= '0;
            best  <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          state <= more ? B_EVAL : B_DRAIN;
        end
        B_EVAL: begin
          if (b_rd.rank < f_rd.rank) begin
            j_idx <= j_idx + 1'b1;
          end else begin
            prod     <= prod_full[thlmpq_pkg::FRAC_BITS +: thlmpq_pkg::PROB_BITS];
            i_idx    <= i_idx + 1'b1;
          end
          state <= B_READ;
        end
        B_DRAIN: begin
          state <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || m_tready) begin
            out_best  <= best;
            out_ovf   <= ovf;
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  `THLMPQ_ASSERT_IMPLY(a_eval_in_range, clk, rst, state == B_EVAL, (i_idx < fcnt) && (j_idx < bcnt), "merge evaluated an entry beyond a list count")
  `THLMPQ_ASSERT_IMPLY(a_prod_after_eval, clk, rst, prod_vld, $past(state == B_EVAL), "product marked valid without a merge step")
  `THLMPQ_ASSERT_IMPLY(a_out_no_pending_prod, clk, rst, state == B_OUT, !prod_vld, "result taken while a product was still pending")
  `THLMPQ_ASSERT_NEXT(a_merge_start, clk, rst, (state == B_IDLE) && q_pop && q_cmd.merge, (state == B_READ) && (i_idx == '0) && (j_idx == '0) && (best == '0), "merge did not start from cleared indices")

endmodule

`default_nettype wire

@@ sv/two_hop_label_max_product_query_core.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core
// Loads a forward and a backward label list and returns the largest product
// of probabilities over landmarks that the two lists share.
// ----------------------------------------------------------------------------
// Label items are taken at one transfer per clock while the four-entry
// command queue has room; each entry is written to its store as it leaves
// the queue. When the item that closes the second list arrives, the back
// end takes its command from the queue and merges the stored lists with
// one read port per store and one multiplier: each merge step is a store
// read, then a compare and multiply, there are at most forward count plus
// backward count steps, and a last read, a drain state and the output load
// bring the result to the output register. Input stalls only while the
// queue is full behind a running merge or behind a result that waits to be
// taken. The result is one transfer holding the maximum truncated product
// (0 if nothing matched) and a flag that is set when either list had
// entries dropped beyond 64.
// ----------------------------------------------------------------------------
`default_nettype none

module two_hop_label_max_product_query_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // tdata: has_entry, landmark_node, landmark_rank, path_prob (lowest bit up)
  input  wire logic [thlmpq_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: list_select
  input  wire logic                                s_tuser,
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // tdata: best_prob, overflow (lowest bit up)
  output logic [thlmpq_pkg::OUT_DATA_W-1:0]        m_tdata
);

  thlmpq_pkg::cmd_t push_cmd;
  thlmpq_pkg::cmd_t pop_cmd;
  logic             push;
  logic             push_ready;
  logic             pop;
  logic             pop_valid;

  thlmpq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_push   (push),
    .q_cmd    (push_cmd),
    .q_ready  (push_ready)
  );

  thlmpq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  thlmpq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (pop_cmd),
    .q_valid  (pop_valid),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_two_hop_label_max_product_query_core.sv @@
// ----------------------------------------------------------------------------
// Two-hop label query core: testbench
// Sends forward and backward label lists as streams and checks each returned
// maximum product and overflow flag against a predictor kept in the bench.
// The run opens with a few hand-built queries covering the extreme values,
// the saturated probabilities, the bare end marks and the ignored items. It
// then sends random queries with mostly sorted lists that share landmarks,
// with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_hop_label_max_product_query_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB           = thlmpq_pkg::NODE_BITS;
  localparam int RB           = thlmpq_pkg::RANK_BITS;
  localparam int PB           = thlmpq_pkg::PROB_BITS;
  localparam int HAS_BIT      = 0;
  localparam int NODE_LSB     = 1;
  localparam int RANK_LSB     = NODE_LSB + NB;
  localparam int PROB_LSB     = RANK_LSB + RB;
  localparam int OVF_BIT      = PB;
  localparam int TARGET_ITEMS = 550;
  localparam int DRAIN_CYCLES = 300;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct {
    logic          sel;
    logic          has;
    logic [NB-1:0] node;
    logic [RB-1:0] rank;
    logic [PB-1:0] prob;
    logic          last;
  } label_item_t;

  typedef struct {
    logic [PB-1:0] best;
    logic          overflow;
  } query_result_t;

  class label_query_scoreboard;
    thlmpq_pkg::entry_t fwd_labels[thlmpq_pkg::MAX_LABELS];
    thlmpq_pkg::entry_t bwd_labels[thlmpq_pkg::MAX_LABELS];
    int unsigned        fwd_count;
    int unsigned        bwd_count;
    logic [1:0]         lists_done;
    logic               overflow_seen;
    query_result_t      expected_results[$];
    int unsigned        mismatches;
    int unsigned        label_items;
    int unsigned        queries;
    int unsigned        matched_results;
    int unsigned        overflow_results;

    function logic [PB-1:0] max_shared_product();
      int unsigned      i;
      int unsigned      j;
      logic [2*PB-1:0]  prod;
      logic [PB-1:0]    best;
      j = 0;
      best = '0;
      for (i = 0; i < fwd_count && j < bwd_count; i++) begin
        while (j < bwd_count && bwd_labels[j].rank < fwd_labels[i].rank) j++;
        if (j < bwd_count && bwd_labels[j].node == fwd_labels[i].node) begin
          prod = fwd_labels[i].prob * bwd_labels[j].prob;
          prod = prod >> thlmpq_pkg::FRAC_BITS;
          if (prod > best) best = PB'(prod);
        end
      end
      return best;
    endfunction

    function void note_label(label_item_t it);
      logic [1:0]         done_bit;
      thlmpq_pkg::entry_t ent;
      query_result_t      res;
      done_bit = (it.sel == thlmpq_pkg::SEL_BWD) ? 2'b10 : 2'b01;
      if ((lists_done & done_bit) != 0) return;
      if (it.has || it.last) label_items++;
      ent.node = it.node;
      ent.rank = it.rank;
      ent.prob = (it.prob > thlmpq_pkg::PROB_ONE) ? thlmpq_pkg::PROB_ONE : it.prob;
      if (it.has) begin
        if (it.sel == thlmpq_pkg::SEL_BWD && bwd_count < thlmpq_pkg::MAX_LABELS) begin
          bwd_labels[bwd_count] = ent;
          bwd_count++;
        end else if (it.sel == thlmpq_pkg::SEL_FWD && fwd_count < thlmpq_pkg::MAX_LABELS) begin
          fwd_labels[fwd_count] = ent;
          fwd_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      if (it.last) lists_done = lists_done | done_bit;
      if (lists_done == 2'b11) begin
        res.best = max_shared_product();
        res.overflow = overflow_seen;
        expected_results.insert(expected_results.size(), res);
        queries++;
        if (res.best != 0) matched_results++;
        if (res.overflow) overflow_results++;
        fwd_count = 0;
        bwd_count = 0;
        lists_done = 2'b00;
        overflow_seen = 1'b0;
      end
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [thlmpq_pkg::OUT_DATA_W-1:0] data);
      query_result_t got;
      query_result_t want;
      got.best = data[PB-1:0];
      got.overflow = data[OVF_BIT];
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result: best_prob=%0d overflow=%0b",
                               got.best, got.overflow));
        return;
      end
      want = expected_results.pop_front();
      if (got.best !== want.best)
        note_failure($sformatf("best_prob: expected %0d, got %0d", want.best, got.best));
      if (got.overflow !== want.overflow)
        note_failure($sformatf("overflow: expected %0b, got %0b",
                               want.overflow, got.overflow));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic [thlmpq_pkg::IN_DATA_W-1:0]      s_tdata = '0;
  logic                                  s_tuser = 1'b0;
  logic                                  s_tlast = 1'b0;
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic [thlmpq_pkg::OUT_DATA_W-1:0]     m_tdata;

  label_query_scoreboard sb;
  label_item_t           query_items[$];
  label_item_t           fwd_items[$];
  label_item_t           bwd_items[$];
  label_item_t           landmark_pool[$];
  logic                  steady = 1'b0;
  int unsigned           idle_cycles = 0;
  int unsigned           sent_items = 0;

  two_hop_label_max_product_query_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [PB-1:0] draw_prob();
    case ($urandom_range(0, 7))
      0: return thlmpq_pkg::PROB_ONE;
      1: return PB'($urandom_range(65537, 131071));
      default: return PB'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic label_item_t random_label(logic sel);
    label_item_t it;
    it.sel = sel;
    it.has = 1'($urandom_range(0, 1));
    it.node = NB'($urandom);
    it.rank = RB'($urandom);
    it.prob = PB'($urandom_range(0, 131071));
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void add_item(logic sel, logic has, logic [NB-1:0] node,
                                   logic [RB-1:0] rank, logic [PB-1:0] prob,
                                   logic last);
    label_item_t it;
    it.sel = sel;
    it.has = has;
    it.node = node;
    it.rank = rank;
    it.prob = prob;
    it.last = last;
    query_items.insert(query_items.size(), it);
  endfunction

  function automatic int draw_list_length();
    int r;
    r = $urandom_range(0, 29);
    if (r == 0) return $urandom_range(60, 70);
    if (r < 3) return 0;
    return $urandom_range(1, 8);
  endfunction

  // Picks an ordered subset of the landmark pool, so that both lists keep the
  // pool's rank order and can share landmarks.
  function automatic void fill_list(logic sel, int len);
    label_item_t list_q[$];
    label_item_t it;
    int          need;
    int          left;
    for (int k = 0; k < landmark_pool.size(); k++) begin
      need = len - list_q.size();
      left = landmark_pool.size() - k;
      if (need > 0 && (need >= left || $urandom_range(0, left - 1) < need)) begin
        it = landmark_pool[k];
        it.sel = sel;
        it.has = 1'b1;
        it.last = 1'b0;
        it.prob = draw_prob();
        if ($urandom_range(0, 5) == 0) it.node = NB'($urandom);
        list_q.insert(list_q.size(), it);
      end
    end
    if (len == 0 || $urandom_range(0, 2) == 0) begin
      it = random_label(sel);
      it.has = 1'b0;
      it.last = 1'b1;
      list_q.insert(list_q.size(), it);
    end else begin
      list_q[list_q.size() - 1].last = 1'b1;
    end
    if (sel == thlmpq_pkg::SEL_BWD) bwd_items = list_q;
    else fwd_items = list_q;
  endfunction

  function automatic void build_random_query();
    int            fwd_len;
    int            bwd_len;
    int            pool_n;
    int            fi;
    int            bi;
    logic          unsorted;
    logic [RB-1:0] rank;
    label_item_t   it;
    fwd_len = draw_list_length();
    bwd_len = draw_list_length();
    pool_n = ((fwd_len > bwd_len) ? fwd_len : bwd_len) + $urandom_range(0, 4);
    unsorted = ($urandom_range(0, 7) == 0);
    rank = RB'($urandom_range(0, 20'hFFFFF - 4 * pool_n));
    landmark_pool.delete();
    for (int k = 0; k < pool_n; k++) begin
      it = random_label(thlmpq_pkg::SEL_FWD);
      it.rank = unsorted ? RB'($urandom) : rank;
      landmark_pool.insert(landmark_pool.size(), it);
      rank = rank + RB'($urandom_range(0, 3));
    end
    fill_list(thlmpq_pkg::SEL_FWD, fwd_len);
    fill_list(thlmpq_pkg::SEL_BWD, bwd_len);
    fi = 0;
    bi = 0;
    while (fi < fwd_items.size() || bi < bwd_items.size()) begin
      if ($urandom_range(0, 11) == 0) begin
        it = random_label(1'($urandom_range(0, 1)));
        it.has = 1'b0;
        it.last = 1'b0;
        query_items.insert(query_items.size(), it);
      end else if (fi == fwd_items.size() && $urandom_range(0, 5) == 0) begin
        query_items.insert(query_items.size(), random_label(thlmpq_pkg::SEL_FWD));
      end else if (bi == bwd_items.size() && $urandom_range(0, 5) == 0) begin
        query_items.insert(query_items.size(), random_label(thlmpq_pkg::SEL_BWD));
      end else if (fi < fwd_items.size() && (bi == bwd_items.size() || $urandom_range(0, 1))) begin
        query_items.insert(query_items.size(), fwd_items[fi]);
        fi++;
      end else begin
        query_items.insert(query_items.size(), bwd_items[bi]);
        bi++;
      end
    end
  endfunction

  function automatic logic [thlmpq_pkg::IN_DATA_W-1:0] pack_label(label_item_t it);
    logic [thlmpq_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[HAS_BIT] = it.has;
    d[NODE_LSB +: NB] = it.node;
    d[RANK_LSB +: RB] = it.rank;
    d[PROB_LSB +: PB] = it.prob;
    return d;
  endfunction

  task automatic put_label(label_item_t it);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_label(it);
    s_tuser <= it.sel;
    s_tlast <= it.last;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    sb.note_label(it);
  endtask

  task automatic send_query();
    foreach (query_items[k]) put_label(query_items[k]);
    query_items.delete();
  endtask

  initial begin
    sb = new();
    fork
      begin : result_sink
        int stall;
        forever begin
          stall = steady ? 0 : $urandom_range(0, 4);
          if (stall > 0) begin
            m_tready <= 1'b0;
            repeat (stall) @(posedge clk);
          end
          m_tready <= 1'b1;
          do @(posedge clk); while (!m_tvalid);
          sb.check_result(m_tdata);
        end
      end
    join_none

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Both lists at full probability on landmark zero.
    add_item(thlmpq_pkg::SEL_FWD, 1'b1, '0, '0, thlmpq_pkg::PROB_ONE, 1'b1);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, '0, '0, thlmpq_pkg::PROB_ONE, 1'b1);
    // Top node and rank with probabilities above one, an empty item and a
    // backward list closed by a bare end mark.
    add_item(thlmpq_pkg::SEL_BWD, 1'b0, '0, '0, '0, 1'b0);
    add_item(thlmpq_pkg::SEL_FWD, 1'b1, '1, '1, 17'h1FFFF, 1'b1);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, '1, '1, 17'h18000, 1'b0);
    add_item(thlmpq_pkg::SEL_BWD, 1'b0, '0, '0, '0, 1'b1);
    // Two empty lists, with an entry sent to the closed backward list.
    add_item(thlmpq_pkg::SEL_BWD, 1'b0, '0, '0, '0, 1'b1);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, 20'd5, 20'd5, thlmpq_pkg::PROB_ONE, 1'b1);
    add_item(thlmpq_pkg::SEL_FWD, 1'b0, '0, '0, '0, 1'b1);
    // Lower backward ranks are skipped; equal rank with a different node
    // does not match, the later shared landmark does.
    add_item(thlmpq_pkg::SEL_FWD, 1'b1, 20'd1, 20'd5, 17'd40000, 1'b0);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, 20'd7, 20'd3, 17'd60000, 1'b0);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, 20'd3, 20'd5, thlmpq_pkg::PROB_ONE, 1'b0);
    add_item(thlmpq_pkg::SEL_FWD, 1'b1, 20'd7, 20'd10, 17'd50000, 1'b1);
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, 20'd7, 20'd10, 17'd30000, 1'b1);
    // A product that truncates to zero.
    add_item(thlmpq_pkg::SEL_BWD, 1'b1, 20'd9, 20'd2, 17'd1, 1'b1);
    add_item(thlmpq_pkg::SEL_FWD, 1'b1, 20'd9, 20'd2, 17'd3, 1'b1);
    send_query();

    while (sent_items < TARGET_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      build_random_query();
      send_query();
    end
    s_tvalid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d queries from %0d input transfers, %0d of them entries or end marks.",
             sb.queries, sent_items, sb.label_items);
    $display("%0d results had a shared landmark, %0d flagged dropped entries, %0d mismatches.",
             sb.matched_results, sb.overflow_results, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
